[rtl/assert_macros.svh]
// Assertion macros shared by the membership view arbiter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MVA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define MVA_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define MVA_ASSERT(label, clk, rst_n, prop)
`define MVA_ASSERT_NR(label, clk, prop)
`endif
`endif

[rtl/mva_pkg.sv]
// Package of types, constants and register indexes for the membership view arbiter.
package mva_pkg;
  localparam int unsigned MaxNodes = 8;
  localparam int unsigned IdW      = 3;
  localparam int unsigned CntW     = 4;

  typedef logic [MaxNodes-1:0] node_vec_t;
  typedef logic [IdW-1:0]      node_id_t;

  localparam logic [1:0] RegNodeCount = 2'd0;
  localparam logic [1:0] RegOwnId     = 2'd1;
  localparam logic [1:0] RegArbEn     = 2'd2;
  localparam logic [1:0] RegPeriod    = 2'd3;

  // Control from the sequencer to the compare unit.
  typedef struct packed {
    node_id_t  a;
    node_id_t  b;
  } pair_sel_t;

  // Result of the shared pair compare unit.
  typedef struct packed {
    logic     drop_valid;
    node_id_t drop;
    node_id_t helped;
  } pair_res_t;
endpackage

[rtl/mva_pair_unit.sv]
// Shared compare unit that judges one node pair per cycle for ostracism.
module mva_pair_unit (
  input  mva_pkg::pair_sel_t sel_i,
  input  mva_pkg::node_vec_t skip_i,
  input  mva_pkg::node_vec_t view_a_i,
  input  mva_pkg::node_vec_t view_b_i,
  output mva_pkg::pair_res_t res_o
);
  import mva_pkg::*;
  logic ab, ba;
  always_comb begin
    ab = view_a_i[sel_i.b];
    ba = view_b_i[sel_i.a];
    res_o.drop_valid = !skip_i[sel_i.a] && !skip_i[sel_i.b] && !(ab && ba);
    res_o.drop   = ab ? sel_i.a : sel_i.b;
    res_o.helped = ab ? sel_i.b : sel_i.a;
  end
endmodule

[rtl/membership_view_arbiter.sv]
// Top level of the membership view arbiter: register file, sequencer and result port.
//
//  channel | direction | handshake          | payload
//  item    | in        | start / busy       | kind_i, sender_*_i
//  config  | in        | cfg_valid_i/ready_o| cfg_index_i, cfg_data_i
//  result  | out       | result_valid_o     | membership_o ... ostracised_for_o
//
// A received view or a tick that does not end the period is absorbed while the block stays idle.
// A tick that starts a round keeps busy high for 64 pair steps, 16 vote steps (8 to find
// the largest received epoch, 8 to count votes) and a finish step, the pair steps being
// left out with arbitration off: the sequencer walks every (i, j) pair of an 8 by 8 grid
// through one pair compare unit. The result strobe follows in the first idle cycle,
// lasts one cycle and cannot be stalled. Reset returns all state to its power-up values.
module membership_view_arbiter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        kind_i,
  input  logic [2:0]  sender_id_i,
  input  logic [7:0]  sender_epoch_i,
  input  logic [7:0]  sender_view_i,
  input  logic        sender_same_flag_i,
  input  logic        sender_ostracised_for_me_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        result_valid_o,
  output logic [7:0]  membership_o,
  output logic [7:0]  epoch_o,
  output logic        membership_updated_o,
  output logic        majority_lost_o,
  output logic [7:0]  heartbeat_view_o,
  output logic        heartbeat_same_o,
  output logic [7:0]  ostracised_for_o
);
  import mva_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [1:0] {StIdle, StPair, StVote, StDone} state_e;

  state_e     state_q;
  logic [5:0] step_q;
  node_vec_t  rv_q [MaxNodes];
  logic [7:0] re_q [MaxNodes];
  node_vec_t  rs_q, ro_q, rf_q, om_q, lv_q, gm_q, last_q;
  logic [7:0] le_q, maxe_q, maxr_q;
  logic       same_q, last_same_q, upd_q, lost_q, vote_q;
  logic [3:0] agree_q;
  logic [15:0] tick_q;
  logic [3:0]  nc_q;
  node_id_t    own_q;
  logic        arb_q;
  logic [15:0] per_q;
  logic        row_skip_q;

  // Configuration writes are accepted whenever the block is idle.
  assign cfg_ready_o = (state_q == StIdle);
  assign busy = (state_q != StIdle);

  logic [3:0] n_walk, maj;
  always_comb begin
    n_walk = (nc_q < 4'd2) ? 4'd2 : (nc_q > 4'd8) ? 4'd8 : nc_q;
    maj = (n_walk == 4'd2) ? 4'd2 : {1'b0, n_walk[3:1]} + 4'd1;
  end

  // Pair step: step_q[5:3] is i, step_q[2:0] is j; pairs with j <= i are idle.
  // The skip test for node i is taken once at the start of its row, so a node that
  // is dropped within its own row still meets the remaining nodes of that row.
  pair_sel_t sel;
  pair_res_t res;
  node_vec_t skip;
  node_vec_t skip_row;
  logic      pair_live;
  always_comb begin
    sel.a = step_q[5:3];
    sel.b = step_q[2:0];
    for (int k = 0; k < MaxNodes; k++)
      skip[k] = (IdW'(k) == own_q) || !rf_q[k] || ro_q[k] || !rv_q[k][own_q];
    skip_row = skip;
    skip_row[sel.a] = row_skip_q;
    pair_live = (step_q[2:0] > step_q[5:3]) && ({1'b0, step_q[2:0]} < n_walk);
  end

  mva_pair_unit u_pair (
    .sel_i(sel), .skip_i(skip_row), .view_a_i(rv_q[sel.a]), .view_b_i(rv_q[sel.b]),
    .res_o(res)
  );

  logic [7:0] pop_last, pop_lv;
  always_comb begin
    pop_last = '0;
    pop_lv   = '0;
    for (int k = 0; k < MaxNodes; k++) begin
      pop_last = pop_last + 8'(last_q[k]);
      pop_lv   = pop_lv + 8'(lv_q[k]);
    end
  end

  node_id_t vi;
  assign vi = step_q[2:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q <= '0;
      for (int k = 0; k < MaxNodes; k++) begin
        rv_q[k] <= '0;
        re_q[k] <= '0;
      end
      rs_q <= '0; ro_q <= '0; rf_q <= '0; om_q <= '0;
      lv_q <= 8'd1; gm_q <= 8'd1; last_q <= 8'd1;
      le_q <= '0; maxe_q <= '0; maxr_q <= '0;
      same_q <= 1'b0; last_same_q <= 1'b0; upd_q <= 1'b0; lost_q <= 1'b0;
      vote_q <= 1'b0; agree_q <= '0; tick_q <= '0;
      nc_q <= 4'd3; own_q <= '0; arb_q <= 1'b1; per_q <= 16'd10;
      row_skip_q <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          RegNodeCount: nc_q <= cfg_data_i[3:0];
          RegOwnId:     own_q <= cfg_data_i[2:0];
          RegArbEn:     arb_q <= cfg_data_i[0];
          RegPeriod:    per_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        StIdle: begin
          if (start && !busy) begin
            if (!kind_i) begin
              rv_q[sender_id_i] <= sender_view_i;
              re_q[sender_id_i] <= sender_epoch_i;
              rs_q[sender_id_i] <= sender_same_flag_i;
              ro_q[sender_id_i] <= sender_ostracised_for_me_i;
              rf_q[sender_id_i] <= 1'b1;
              lv_q[sender_id_i] <= 1'b1;
            end else begin
              logic [15:0] t;
              t = (tick_q != 16'hFFFF) ? tick_q + 16'd1 : tick_q;
              if (t > per_q) begin
                tick_q <= '0;
                step_q <= '0;
                if (arb_q) om_q <= '0;
                state_q <= arb_q ? StPair : StVote;
                maxr_q <= '0;
              end else begin
                tick_q <= t;
              end
            end
          end
        end
        StPair: begin
          if (step_q[2:0] == 3'd0) row_skip_q <= skip[step_q[5:3]];
          if (pair_live && res.drop_valid) begin
            rf_q[res.drop] <= 1'b0;
            lv_q[res.drop] <= 1'b0;
            om_q[res.helped] <= 1'b1;
          end
          step_q <= step_q + 6'd1;
          if (step_q == 6'd63) state_q <= StVote;
        end
        StVote: begin
          // Step 0..7 gathers the maximum received epoch, 8..15 the vote.
          if (!step_q[3]) begin
            if ({1'b0, vi} < n_walk && rf_q[vi] && re_q[vi] > maxr_q)
              maxr_q <= re_q[vi];
            if (vi == 3'd7) begin
              vote_q  <= (lv_q != gm_q);
              agree_q <= 4'd1;
              maxe_q  <= le_q;
              same_q  <= 1'b0;
            end
          end else begin
            if (step_q[2:0] == 3'd0) vote_q <= vote_q || (maxr_q > le_q);
            if ((vote_q || maxr_q > le_q) && {1'b0, vi} < n_walk && vi != own_q
                && rf_q[vi]) begin
              if (rv_q[vi] == lv_q) begin
                agree_q <= agree_q + 4'd1;
                if (maxe_q < re_q[vi]) begin
                  maxe_q <= re_q[vi];
                  same_q <= rs_q[vi];
                end
              end
              rf_q[vi] <= 1'b0;
            end
          end
          if (step_q[3:0] == 4'd15) state_q <= StDone;
          step_q <= {2'b00, step_q[3:0] + 4'd1};
        end
        StDone: begin
          logic do_upd;
          node_vec_t nm;
          do_upd = (vote_q || maxr_q > le_q) && (agree_q >= maj);
          nm = do_upd ? lv_q : gm_q;
          if (do_upd) begin
            le_q <= maxe_q + (same_q ? 8'd0 : 8'd1);
            gm_q <= lv_q;
          end
          upd_q <= do_upd;
          lost_q <= (pop_last >= 8'(maj)) && (pop_lv < 8'(maj));
          last_q <= lv_q;
          last_same_q <= (lv_q == nm);
          lv_q <= node_vec_t'(1) << own_q;
          result_valid_o <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign membership_o = gm_q;
  assign epoch_o = le_q;
  assign membership_updated_o = upd_q;
  assign majority_lost_o = lost_q;
  assign heartbeat_view_o = last_q;
  assign heartbeat_same_o = last_same_q;
  assign ostracised_for_o = om_q;

  `MVA_ASSERT(a_strobe_after_done, clk_i, rst_ni, result_valid_o |-> !busy)
  `MVA_ASSERT(a_no_cfg_busy, clk_i, rst_ni, busy |-> !cfg_ready_o)
  `MVA_ASSERT(a_strobe_single, clk_i, rst_ni, result_valid_o |=> !result_valid_o)
endmodule
